// ===== src/nss_pkg.sv =====
// Shared types and constants for the nearest segment search unit.
// No dependencies; every other file takes names from here by scope.
package nss_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = 17;
    localparam int PROD_W     = 34;
    localparam int CLR_W      = 15;
    localparam int CLRSQ_W    = 30;
    localparam int NN_W       = 33;
    localparam int CR_W       = 33;
    localparam int CR_HI_W    = 16;
    localparam int CR_LO_W    = 17;
    localparam int CRSQ_W     = 66;
    localparam int QUO_W      = 34;
    localparam int DIST_W     = 35;
    localparam int CFG_W      = 9;
    localparam int IDX_PORT_W = 8;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic [CLR_W-1:0]          clr;
    } seg_entry_t;

    typedef struct packed {
        logic wr_en;    // write one table entry
        logic start;    // latch the query point, clear the best match
        logic issue;    // send one table entry down the distance pipeline
    } dp_cmd_t;

    typedef struct packed {
        logic busy;     // some entry still in flight
    } dp_status_t;

    // One token of the restoring divider pipeline with its sideband.
    typedef struct packed {
        logic                valid;
        logic [NN_W-1:0]     rem;
        logic [QUO_W-1:0]    qd;     // dividend bits out at the top, quotient in at the bottom
        logic [NN_W-1:0]     dvsr;
        logic                foot;   // distance comes from the quotient
        logic [DIST_W-1:0]   alt;    // distance to start or end
        logic [CLRSQ_W-1:0]  clr_sq;
    } div_tok_t;

endpackage

// ===== src/nss_div_stage.sv =====
// One quotient bit of the pipelined restoring divider.
// Depends on nss_pkg (div_tok_t, widths).
module nss_div_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  nss_pkg::div_tok_t tok_in,
    output nss_pkg::div_tok_t tok_out
);

    logic [nss_pkg::NN_W:0] shifted;
    logic                   fits;
    nss_pkg::div_tok_t      tok_next;
    nss_pkg::div_tok_t      tok_reg;

    always_comb
    begin
        tok_next = tok_in;
        shifted  = {tok_in.rem, tok_in.qd[nss_pkg::QUO_W-1]};
        fits     = (shifted >= {1'b0, tok_in.dvsr});
        if (fits)
        begin
            tok_next.rem = nss_pkg::NN_W'(shifted - {1'b0, tok_in.dvsr});
        end
        else
        begin
            tok_next.rem = shifted[nss_pkg::NN_W-1:0];
        end
        tok_next.qd = {tok_in.qd[nss_pkg::QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== src/nss_datapath.sv =====
// Segment table, distance pipeline, divider chain and best-match tracker.
// Depends on nss_pkg and nss_div_stage.
module nss_datapath
#(
    parameter int MAX_SEGMENTS = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  nss_pkg::dp_cmd_t                    cmd,
    input  logic [$clog2(MAX_SEGMENTS)-1:0]     rd_addr,
    input  logic [nss_pkg::IDX_PORT_W-1:0]      seg_index,
    input  nss_pkg::seg_entry_t                 wr_data,
    input  logic signed [nss_pkg::COORD_W-1:0]  point_x,
    input  logic signed [nss_pkg::COORD_W-1:0]  point_y,
    output nss_pkg::dp_status_t                 status,
    output logic                                best_found,
    output logic [nss_pkg::IDX_PORT_W-1:0]      best_idx,
    output logic [nss_pkg::DIST_W-1:0]          best_dist
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int DW    = nss_pkg::DIFF_W;
    localparam int PW    = nss_pkg::PROD_W;
    localparam int SW    = nss_pkg::PROD_W + 1;

    nss_pkg::seg_entry_t seg_mem [MAX_SEGMENTS];

    // query point
    logic signed [nss_pkg::COORD_W-1:0] px_reg, py_reg;

    // stage 0: table read
    nss_pkg::seg_entry_t rd_reg;
    logic                v0_reg;

    // stage 1: differences
    logic signed [DW-1:0] nx_reg, ny_reg, pax_reg, pay_reg, bpx_reg, bpy_reg;
    logic [nss_pkg::CLR_W-1:0] clr1_reg;
    logic                      v1_reg;

    // stage 2: products
    logic signed [PW-1:0] nxnx_reg, nyny_reg, nxpax_reg, nypay_reg, nxbpx_reg, nybpy_reg;
    logic signed [PW-1:0] paxsq_reg, paysq_reg, bpxsq_reg, bpysq_reg, nxpay_reg, nypax_reg;
    logic [nss_pkg::CLRSQ_W-1:0] clrsq2_reg;
    logic                        v2_reg;

    // stage 3: sums and end-region decision
    logic signed [SW-1:0] nn_s, dot_a, dot_b, da_s, db_s, cr_s, cr_abs;
    logic [nss_pkg::NN_W-1:0]    nn3_reg;
    logic [nss_pkg::CR_W-1:0]    cr3_reg;
    logic                        foot3_reg;
    logic [nss_pkg::DIST_W-1:0]  alt3_reg;
    logic [nss_pkg::CLRSQ_W-1:0] clrsq3_reg;
    logic                        v3_reg;

    // stage 4: partial products of the cross product squared
    logic [2*nss_pkg::CR_HI_W-1:0]                  hh_reg;
    logic [nss_pkg::CR_HI_W+nss_pkg::CR_LO_W-1:0]   hl_reg;
    logic [2*nss_pkg::CR_LO_W-1:0]                  ll_reg;
    logic [nss_pkg::NN_W-1:0]    nn4_reg;
    logic                        foot4_reg;
    logic [nss_pkg::DIST_W-1:0]  alt4_reg;
    logic [nss_pkg::CLRSQ_W-1:0] clrsq4_reg;
    logic                        v4_reg;

    // stage 5: divider entry
    logic [nss_pkg::CRSQ_W-1:0] crsq;
    nss_pkg::div_tok_t          tok5_reg;
    nss_pkg::div_tok_t          div_pipe [nss_pkg::QUO_W+1];

    // best match
    nss_pkg::div_tok_t           tok_f;
    logic [nss_pkg::DIST_W-1:0]  fdist;
    logic                        take;
    logic                        best_found_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [nss_pkg::DIST_W-1:0]  best_dist_reg;
    logic [IDX_W-1:0]            res_cnt_reg;
    logic                        div_busy;

    // table
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            seg_mem[IDX_W'(seg_index)] <= wr_data;
        end
        rd_reg <= seg_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= cmd.issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        nn_s   = SW'(nxnx_reg) + SW'(nyny_reg);
        dot_a  = SW'(nxpax_reg) + SW'(nypay_reg);
        dot_b  = SW'(nxbpx_reg) + SW'(nybpy_reg);
        da_s   = SW'(paxsq_reg) + SW'(paysq_reg);
        db_s   = SW'(bpxsq_reg) + SW'(bpysq_reg);
        cr_s   = SW'(nxpay_reg) - SW'(nypax_reg);
        cr_abs = (cr_s < 0) ? -cr_s : cr_s;
    end

    assign crsq = (nss_pkg::CRSQ_W'(hh_reg) << (2 * nss_pkg::CR_LO_W))
                + (nss_pkg::CRSQ_W'(hl_reg) << (nss_pkg::CR_LO_W + 1))
                + nss_pkg::CRSQ_W'(ll_reg);

    // payload stages
    always_ff @(posedge clk)
    begin
        nx_reg   <= DW'(rd_reg.ex) - DW'(rd_reg.sx);
        ny_reg   <= DW'(rd_reg.ey) - DW'(rd_reg.sy);
        pax_reg  <= DW'(rd_reg.sx) - DW'(px_reg);
        pay_reg  <= DW'(rd_reg.sy) - DW'(py_reg);
        bpx_reg  <= DW'(px_reg) - DW'(rd_reg.ex);
        bpy_reg  <= DW'(py_reg) - DW'(rd_reg.ey);
        clr1_reg <= rd_reg.clr;

        nxnx_reg   <= nx_reg * nx_reg;
        nyny_reg   <= ny_reg * ny_reg;
        nxpax_reg  <= nx_reg * pax_reg;
        nypay_reg  <= ny_reg * pay_reg;
        nxbpx_reg  <= nx_reg * bpx_reg;
        nybpy_reg  <= ny_reg * bpy_reg;
        paxsq_reg  <= pax_reg * pax_reg;
        paysq_reg  <= pay_reg * pay_reg;
        bpxsq_reg  <= bpx_reg * bpx_reg;
        bpysq_reg  <= bpy_reg * bpy_reg;
        nxpay_reg  <= nx_reg * pay_reg;
        nypax_reg  <= ny_reg * pax_reg;
        clrsq2_reg <= nss_pkg::CLRSQ_W'(clr1_reg) * nss_pkg::CLRSQ_W'(clr1_reg);

        // zero-length segment or point before the start: distance to start
        nn3_reg    <= nn_s[nss_pkg::NN_W-1:0];
        cr3_reg    <= cr_abs[nss_pkg::CR_W-1:0];
        clrsq3_reg <= clrsq2_reg;
        if ((nn_s == '0) || (dot_a > 0))
        begin
            foot3_reg <= 1'b0;
            alt3_reg  <= nss_pkg::DIST_W'(da_s);
        end
        else if (dot_b > 0)
        begin
            foot3_reg <= 1'b0;
            alt3_reg  <= nss_pkg::DIST_W'(db_s);
        end
        else
        begin
            foot3_reg <= 1'b1;
            alt3_reg  <= '0;
        end

        hh_reg     <= nss_pkg::CR_HI_W'(cr3_reg >> nss_pkg::CR_LO_W)
                    * nss_pkg::CR_HI_W'(cr3_reg >> nss_pkg::CR_LO_W);
        hl_reg     <= (nss_pkg::CR_HI_W+nss_pkg::CR_LO_W)'(cr3_reg >> nss_pkg::CR_LO_W)
                    * (nss_pkg::CR_HI_W+nss_pkg::CR_LO_W)'(cr3_reg[nss_pkg::CR_LO_W-1:0]);
        ll_reg     <= (2*nss_pkg::CR_LO_W)'(cr3_reg[nss_pkg::CR_LO_W-1:0])
                    * (2*nss_pkg::CR_LO_W)'(cr3_reg[nss_pkg::CR_LO_W-1:0]);
        nn4_reg    <= nn3_reg;
        foot4_reg  <= foot3_reg;
        alt4_reg   <= alt3_reg;
        clrsq4_reg <= clrsq3_reg;
    end

    // divider entry: the quotient fits QUO_W bits, so the top part starts below the divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok5_reg <= '0;
        end
        else
        begin
            tok5_reg.valid  <= v4_reg;
            tok5_reg.rem    <= nss_pkg::NN_W'(crsq[nss_pkg::CRSQ_W-1:nss_pkg::QUO_W]);
            tok5_reg.qd     <= crsq[nss_pkg::QUO_W-1:0];
            tok5_reg.dvsr   <= nn4_reg;
            tok5_reg.foot   <= foot4_reg;
            tok5_reg.alt    <= alt4_reg;
            tok5_reg.clr_sq <= clrsq4_reg;
        end
    end

    assign div_pipe[0] = tok5_reg;

    for (genvar k = 0; k < nss_pkg::QUO_W; k++)
    begin : g_div
        nss_div_stage u_stage
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (div_pipe[k]),
            .tok_out (div_pipe[k+1])
        );
    end

    assign tok_f = div_pipe[nss_pkg::QUO_W];
    assign fdist = tok_f.foot ? nss_pkg::DIST_W'(tok_f.qd) : tok_f.alt;
    assign take  = tok_f.valid
                && (fdist <= nss_pkg::DIST_W'(tok_f.clr_sq))
                && (!best_found_reg || (fdist < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_dist_reg  <= '0;
            res_cnt_reg    <= '0;
        end
        else if (cmd.start)
        begin
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_dist_reg  <= '0;
            res_cnt_reg    <= '0;
        end
        else if (tok_f.valid)
        begin
            res_cnt_reg <= res_cnt_reg + 1'b1;
            if (take)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= res_cnt_reg;
                best_dist_reg  <= fdist;
            end
        end
    end

    always_comb
    begin
        div_busy = 1'b0;
        for (int k = 0; k <= nss_pkg::QUO_W; k++)
        begin
            div_busy = div_busy | div_pipe[k].valid;
        end
    end

    assign status.busy = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg | div_busy;
    assign best_found  = best_found_reg;
    assign best_idx    = nss_pkg::IDX_PORT_W'(best_idx_reg);
    assign best_dist   = best_dist_reg;

endmodule

// ===== src/nss_ctrl.sv =====
// Controller: input handshake, count register, entry sequencing, result handoff.
// Depends on nss_pkg (dp_cmd_t, dp_status_t, codes).
module nss_ctrl
#(
    parameter int MAX_SEGMENTS = 256
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [nss_pkg::IDX_PORT_W-1:0]     seg_index,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nss_pkg::CFG_W-1:0]          segment_count,
    output logic                               out_valid,
    input  logic                               out_ready,
    output nss_pkg::dp_cmd_t                   cmd,
    output logic [$clog2(MAX_SEGMENTS)-1:0]    rd_addr,
    input  nss_pkg::dp_status_t                status,
    output logic                               res_load
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [nss_pkg::CFG_W-1:0] count_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     accept;
    logic [CNT_W-1:0]         n_clamped;

    assign accept    = in_valid && in_ready;
    assign n_clamped = (32'(count_reg) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                       : CNT_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        res_load       = 1'b0;
        in_ready       = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == nss_pkg::ACT_LOAD))
                begin
                    cmd.wr_en = (32'(seg_index) < MAX_SEGMENTS);
                end
                else if (accept)
                begin
                    cmd.start = 1'b1;
                    n_next    = n_clamped;
                    cnt_next  = '0;
                    state_next = (n_clamped == '0) ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                cnt_next  = CNT_W'(cnt_reg + 1'b1);
                if (CNT_W'(cnt_reg + 1'b1) == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= segment_count;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign rd_addr   = cnt_reg[IDX_W-1:0];

endmodule

// ===== src/nearest_segment_search_unit.sv =====
// Top level of the nearest segment search unit.
// Depends on nss_pkg, nss_ctrl and nss_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready): one transfer is either a load
//   (action = 0) that writes entry seg_index of the segment table, or a
//   query (action = 1) with a point. A load finishes in the cycle it is
//   taken and gives no result. A query gives exactly one result.
//   Config channel (cfg_valid/cfg_ready): sets segment_count, the number of
//   table entries a query walks; always ready. Write it only while idle.
//   Output channel (out_valid/out_ready): found, best_index, best_dist_sq.
//   A query walks its N entries one per cycle through the distance
//   pipeline (table read, differences, products, sums, squared cross
//   product, a 34-stage restoring divider).
//   Reset clears the count to zero and empties the pipeline; table
//   contents are undefined until loaded.
//   The result sits in an output register; the input is taken again
//   once the query completes. If the receiver stalls with a result still
//   held, a finished query waits until the register frees up.
module nearest_segment_search_unit
#(
    parameter int MAX_SEGMENTS = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [nss_pkg::IDX_PORT_W-1:0]      seg_index,
    input  logic signed [nss_pkg::COORD_W-1:0]  start_x,
    input  logic signed [nss_pkg::COORD_W-1:0]  start_y,
    input  logic signed [nss_pkg::COORD_W-1:0]  end_x,
    input  logic signed [nss_pkg::COORD_W-1:0]  end_y,
    input  logic [nss_pkg::CLR_W-1:0]           clearance,
    input  logic signed [nss_pkg::COORD_W-1:0]  point_x,
    input  logic signed [nss_pkg::COORD_W-1:0]  point_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nss_pkg::CFG_W-1:0]           segment_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [nss_pkg::IDX_PORT_W-1:0]      best_index,
    output logic [nss_pkg::DIST_W-1:0]          best_dist_sq
);

    nss_pkg::dp_cmd_t                   cmd;
    nss_pkg::dp_status_t                status;
    nss_pkg::seg_entry_t                wr_data;
    logic [$clog2(MAX_SEGMENTS)-1:0]    rd_addr;
    logic                               res_load;
    logic                               dp_found;
    logic [nss_pkg::IDX_PORT_W-1:0]     dp_idx;
    logic [nss_pkg::DIST_W-1:0]         dp_dist;

    logic                               found_reg;
    logic [nss_pkg::IDX_PORT_W-1:0]     best_index_reg;
    logic [nss_pkg::DIST_W-1:0]         best_dist_sq_reg;

    // pack the load payload into one table word
    assign wr_data.sx  = start_x;
    assign wr_data.sy  = start_y;
    assign wr_data.ex  = end_x;
    assign wr_data.ey  = end_y;
    assign wr_data.clr = clearance;

    nss_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .seg_index     (seg_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .segment_count (segment_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .status        (status),
        .res_load      (res_load)
    );

    nss_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .seg_index  (seg_index),
        .wr_data    (wr_data),
        .point_x    (point_x),
        .point_y    (point_y),
        .status     (status),
        .best_found (dp_found),
        .best_idx   (dp_idx),
        .best_dist  (dp_dist)
    );

    // hold the result until its transfer; a miss reports all zero
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            found_reg        <= dp_found;
            best_index_reg   <= dp_found ? dp_idx : '0;
            best_dist_sq_reg <= dp_found ? dp_dist : '0;
        end
    end

    assign found        = found_reg;
    assign best_index   = best_index_reg;
    assign best_dist_sq = best_dist_sq_reg;

endmodule

// ===== src/nss_checker.sv =====
// Port-level checks for the nearest segment search unit, bound to the top.
// Depends on nss_pkg and nearest_segment_search_unit.
module nss_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                action,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                found,
    input logic [nss_pkg::IDX_PORT_W-1:0]      best_index,
    input logic [nss_pkg::DIST_W-1:0]          best_dist_sq
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
            && $stable(best_index) && $stable(best_dist_sq))
        else $error("result changed while stalled");

    // a miss reports zeros
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> best_index == '0 && best_dist_sq == '0)
        else $error("miss with nonzero payload");

    // a hit lies within a clearance, so below 2^30
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> best_dist_sq[nss_pkg::DIST_W-1:nss_pkg::CLRSQ_W] == '0)
        else $error("hit distance beyond any clearance");

    // a query transfer blocks input in the next cycle
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == nss_pkg::ACT_QUERY |=> !in_ready)
        else $error("input taken during a query");

endmodule

bind nearest_segment_search_unit nss_checker u_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .best_index   (best_index),
    .best_dist_sq (best_dist_sq)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the nearest segment search unit.
// Depends on nss_pkg and nearest_segment_search_unit; needs no other file.
module tb_top;
    import nss_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    logic action = ACT_LOAD;
    logic [IDX_PORT_W-1:0] seg_index = '0;
    logic signed [COORD_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic [CLR_W-1:0] clearance = '0;
    logic signed [COORD_W-1:0] point_x = '0, point_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] segment_count = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic found;
    logic [IDX_PORT_W-1:0] best_index;
    logic [DIST_W-1:0] best_dist_sq;

    nearest_segment_search_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .seg_index(seg_index),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .clearance(clearance), .point_x(point_x), .point_y(point_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .segment_count(segment_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .best_index(best_index), .best_dist_sq(best_dist_sq)
    );

    always #5 clk = ~clk;

    typedef struct packed {
        logic                  hit;
        logic [IDX_PORT_W-1:0] idx;
        logic [DIST_W-1:0]     dist_sq;
    } search_result_t;

    // Shadow copy of the segment table and the count register.
    seg_entry_t shadow_table [TABLE_DEPTH];
    bit         loaded [TABLE_DEPTH];
    int         shadow_count = 0;

    search_result_t pending_results[$];
    int mismatch_count = 0;
    bit stall_window = 1'b0;

    // Squared distance from a point to one segment, exact integer arithmetic.
    function automatic logic [DIST_W-1:0] seg_distance_sq(seg_entry_t s,
            logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
        longint nx, ny, pax, pay, bpx, bpy, nn, cr;
        logic [127:0] cr_sq, quo;
        nx = s.ex - s.sx;  ny = s.ey - s.sy;
        pax = s.sx - px;   pay = s.sy - py;
        bpx = px - s.ex;   bpy = py - s.ey;
        nn = nx * nx + ny * ny;
        if (nn == 0 || nx * pax + ny * pay > 0)
            return DIST_W'(pax * pax + pay * pay);
        if (nx * bpx + ny * bpy > 0)
            return DIST_W'(bpx * bpx + bpy * bpy);
        cr = nx * pay - ny * pax;
        if (cr < 0)
            cr = -cr;
        cr_sq = 128'(cr) * 128'(cr);
        quo = cr_sq / 128'(nn);
        if (quo > 128'(DIST_SAT))
            return DIST_SAT;
        return DIST_W'(quo);
    endfunction

    // Walk the active entries and pick the nearest one inside its clearance.
    function automatic search_result_t nearest_within_clearance(
            logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
        search_result_t r;
        logic [DIST_W-1:0] d;
        logic [CLRSQ_W-1:0] lim;
        int n;
        r.hit = 1'b0; r.idx = '0; r.dist_sq = '0;
        n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
        for (int i = 0; i < n; i++)
        begin
            d = seg_distance_sq(shadow_table[i], px, py);
            lim = shadow_table[i].clr * shadow_table[i].clr;
            if ((!r.hit || d < r.dist_sq) && d <= DIST_W'(lim))
            begin
                r.hit = 1'b1;
                r.idx = IDX_PORT_W'(i);
                r.dist_sq = d;
            end
        end
        return r;
    endfunction

    // Offer one item and hold it until the transfer happens; valid stays up
    // after the transfer only until the next item or an explicit drop.
    task automatic send_item(logic act, logic [IDX_PORT_W-1:0] idx,
            seg_entry_t s, logic signed [COORD_W-1:0] px,
            logic signed [COORD_W-1:0] py, bit has_known, search_result_t known);
        search_result_t predicted;
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act; seg_index <= idx;
        start_x <= s.sx; start_y <= s.sy; end_x <= s.ex; end_y <= s.ey;
        clearance <= s.clr; point_x <= px; point_y <= py;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (act == ACT_LOAD)
        begin
            shadow_table[idx] = s;
            loaded[idx] = 1'b1;
        end
        else
        begin
            predicted = nearest_within_clearance(px, py);
            if (has_known && predicted != known)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("table row disagrees with predictor: %0b %0d %0d vs %0b %0d %0d",
                             known.hit, known.idx, known.dist_sq,
                             predicted.hit, predicted.idx, predicted.dist_sq);
            end
            pending_results.push_back(predicted);
        end
        @(negedge clk);
    endtask

    // Drain, let the pipeline settle, then write the count register.
    task automatic write_count(int value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (TABLE_DEPTH + 60) @(negedge clk);
        cfg_valid <= 1'b1;
        segment_count <= CFG_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_count = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic seg_entry_t random_segment(int span);
        seg_entry_t s;
        int cx, cy;
        if (span == 0)
        begin
            s.sx = COORD_W'($urandom); s.sy = COORD_W'($urandom);
            s.ex = COORD_W'($urandom); s.ey = COORD_W'($urandom);
            s.clr = CLR_W'($urandom);
        end
        else
        begin
            cx = $signed(16'($urandom)) / 2;
            cy = $signed(16'($urandom)) / 2;
            s.sx = COORD_W'(cx + $urandom_range(0, 2 * span) - span);
            s.sy = COORD_W'(cy + $urandom_range(0, 2 * span) - span);
            s.ex = COORD_W'(cx + $urandom_range(0, 2 * span) - span);
            s.ey = COORD_W'(cy + $urandom_range(0, 2 * span) - span);
            s.clr = CLR_W'($urandom_range(0, 4 * span));
            if ($urandom_range(0, 15) == 0)
                s.ex = s.sx;
            if ($urandom_range(0, 15) == 0)
                s.ey = s.sy;
        end
        return s;
    endfunction

    // Receiver: random backpressure, plus a long hold-off window.
    initial
    begin
        int wait_cycles;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_window)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                wait_cycles = $urandom_range(0, 8);
                if ($urandom_range(0, 3) == 0)
                    wait_cycles = 0;
                if (wait_cycles != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (wait_cycles) @(negedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
                while (!(out_valid && out_ready) && !stall_window)
                    @(posedge clk);
            end
        end
    end

    // Compare every result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        search_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %0b %0d %0d", found, best_index, best_dist_sq);
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.hit || best_index !== want.idx
                        || best_dist_sq !== want.dist_sq)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: want %0b %0d %0d got %0b %0d %0d",
                                 want.hit, want.idx, want.dist_sq,
                                 found, best_index, best_dist_sq);
                end
            end
        end
    end

    // Hold the receiver off for a long stretch once, counted in cycles.
    initial
    begin
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        stall_window = 1'b1;
        repeat (2500) @(posedge clk);
        stall_window = 1'b0;
    end

    initial
    begin
        #300_000_000;
        $display("FAIL nearest_segment_search_unit");
        $finish;
    end

    typedef struct {
        logic           act;
        logic [7:0]     idx;
        seg_entry_t     seg;
        logic signed [COORD_W-1:0] px, py;
        bit             known;
        search_result_t res;
    } stim_row_t;

    stim_row_t directed_rows[$];

    function automatic stim_row_t mk(logic act, logic [7:0] idx,
            int sx, int sy, int ex, int ey, int clr, int px, int py,
            bit known, logic hit, int ridx, longint dsq);
        stim_row_t r;
        r.act = act; r.idx = idx;
        r.seg.sx = COORD_W'(sx); r.seg.sy = COORD_W'(sy);
        r.seg.ex = COORD_W'(ex); r.seg.ey = COORD_W'(ey);
        r.seg.clr = CLR_W'(clr); r.px = COORD_W'(px); r.py = COORD_W'(py);
        r.known = known;
        r.res.hit = hit; r.res.idx = IDX_PORT_W'(ridx); r.res.dist_sq = DIST_W'(dsq);
        return r;
    endfunction

    initial
    begin
        search_result_t none;
        seg_entry_t s;
        int count_choice, n_queries;
        none.hit = 0; none.idx = 0; none.dist_sq = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Count is zero after reset: a query searches nothing.
        send_item(ACT_QUERY, 0, '0, 16'sh7fff, -16'sh8000, 1'b1, none);

        // Fill the table with random short segments before any wider search.
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(ACT_LOAD, IDX_PORT_W'(i), random_segment(400), 0, 0, 1'b0, none);

        // Directed: zero-length segments, perpendicular foot, extremes, ties.
        directed_rows.push_back(mk(ACT_LOAD, 0, 0, 0, 0, 0, 256, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_LOAD, 1, -256, 512, 256, 512, 1024, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_LOAD, 2, -32768, -32768, 32767, 32767, 32767,
                                   0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_LOAD, 3, 100, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 100, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 512, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 32767, -32768, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, -32768, 32767, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 1000, 600, 0, 0, 0, 0));
        directed_rows.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, -32768, -32768, 0, 0, 0, 0));

        write_count(4);
        foreach (directed_rows[k])
        begin
            // Queries first need the loads of this phase in the shadow table.
            send_item(directed_rows[k].act, directed_rows[k].idx, directed_rows[k].seg,
                      directed_rows[k].px, directed_rows[k].py,
                      directed_rows[k].known, directed_rows[k].res);
        end
        // Ties: identical segments at 0 and 1 (a tie goes to the lower index); entry 2 lies nearer this point.
        s.sx = 0; s.sy = 0; s.ex = 256; s.ey = 0; s.clr = 512;
        send_item(ACT_LOAD, 0, s, 0, 0, 1'b0, none);
        send_item(ACT_LOAD, 1, s, 0, 0, 1'b0, none);
        send_item(ACT_QUERY, 0, '0, 128, 64, 1'b0, none);

        // Count above the table size and the maximum register value.
        write_count(511);
        send_item(ACT_QUERY, 0, '0, 0, 0, 1'b0, none);
        send_item(ACT_QUERY, 0, '0, 16'sh7fff, 16'sh7fff, 1'b0, none);
        write_count(257);
        send_item(ACT_QUERY, 0, '0, 100, -100, 1'b0, none);

        // Random phases with counts that include the extremes.
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: count_choice = 0;
                1: count_choice = 1;
                2: count_choice = 256;
                3: count_choice = 2;
                default: count_choice = $urandom_range(1, 64);
            endcase
            write_count(count_choice);
            n_queries = (count_choice > 100) ? 15 : 105;
            for (int k = 0; k < n_queries; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    s = random_segment($urandom_range(0, 3) == 0 ? 0 : 300);
                    send_item(ACT_LOAD, IDX_PORT_W'($urandom_range(0, 255)), s, 0, 0,
                              1'b0, none);
                end
                else
                begin
                    // Aim most queries near a loaded segment so hits occur.
                    s = shadow_table[$urandom_range(0, (count_choice > 0 ?
                        (count_choice > 256 ? 255 : count_choice - 1) : 0))];
                    if ($urandom_range(0, 4) == 0)
                        send_item(ACT_QUERY, IDX_PORT_W'($urandom), '0,
                                  COORD_W'($urandom), COORD_W'($urandom), 1'b0, none);
                    else
                        send_item(ACT_QUERY, IDX_PORT_W'($urandom), '0,
                                  s.sx + $signed(10'($urandom)), s.sy + $signed(10'($urandom)),
                                  1'b0, none);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS nearest_segment_search_unit");
        else
            $display("FAIL nearest_segment_search_unit");
        $finish;
    end
endmodule

// ===== files.f =====
src/nss_pkg.sv
src/nss_div_stage.sv
src/nss_datapath.sv
src/nss_ctrl.sv
src/nearest_segment_search_unit.sv
src/nss_checker.sv
tb/sv/tb_top.sv
